FILE: sv/fmtc_pkg.sv
// Package: shared types and constants for the follow-mode transition controller.
`timescale 1ns / 1ps
package fmtc_pkg;

    localparam int SLOT_COUNT  = 8;
    localparam int EASE_MS_DEF = 150;
    localparam int LEVEL_W     = 17;
    localparam int TIME_W      = 64;
    localparam int CFG_W       = 16;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 32;

    localparam logic [CFG_W-1:0]   WINDOW_RESET = 16'd750;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL   = 17'h10000;
    localparam logic [LEVEL_W-1:0] ZERO_LEVEL   = 17'h00000;
    localparam logic signed [3:0]  NO_SLOT      = -4'sd1;

    // input word, lowest bits last
    typedef struct packed {
        logic signed [3:0]  query_slot;
        logic signed [3:0]  candidate_slot;
        logic [TIME_W-1:0]  time_ms;
        logic               follow_request;
        logic               pose_valid;
    } t_in_word;

    // result word, lowest bits last
    typedef struct packed {
        logic               easing;
        logic               query_centring;
        logic [LEVEL_W-1:0] progress_level;
        logic signed [3:0]  reported_slot;
        logic               pose_held;
        logic               use_origin;
    } t_out_word;

    localparam int IN_W  = $bits(t_in_word);
    localparam int OUT_W = $bits(t_out_word);

endpackage

FILE: sv/fmtc_in_reg.sv
// Input register: captures one update word from the slave stream.
`timescale 1ns / 1ps
module fmtc_in_reg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [fmtc_pkg::S_TDATA_W-1:0] i_data,
    input  logic                           i_take,
    output logic                           o_valid,
    output fmtc_pkg::t_in_word             o_word
);
    import fmtc_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= t_in_word'(i_data[IN_W-1:0]);
        end
    end

endmodule

FILE: sv/fmtc_core.sv
// Core: follow-mode state, disabling window and linear centring ease.
`timescale 1ns / 1ps
module fmtc_core #(
    parameter int EASE_MS = fmtc_pkg::EASE_MS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [fmtc_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_step,
    input  fmtc_pkg::t_in_word         i_word,
    output fmtc_pkg::t_out_word        o_result
);
    import fmtc_pkg::*;

    // floor(x / EASE_MS) as (x * RECIP) >> SH, exact for x < 2^(LEVEL_W + EW)
    localparam int EW = (EASE_MS > 1) ? $clog2(EASE_MS) : 1;
    localparam int SH = LEVEL_W + 2 * EW;
    localparam int RW = SH - EW + 2;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << SH) + 64'(EASE_MS) - 64'd1) / 64'(EASE_MS));
    localparam int KW = LEVEL_W + RW;
    localparam int PW = KW + EW;
    localparam logic [TIME_W-1:0] EASE_LEN = TIME_W'(EASE_MS);

    logic [CFG_W-1:0]   r_cfg_window;
    logic               r_prev_active, n_prev_active;
    logic               r_window_open, n_window_open;
    logic [TIME_W-1:0]  r_window_end, n_window_end;
    logic               r_ease_running, n_ease_running;
    logic               r_ease_goal_full, n_ease_goal_full;
    logic [TIME_W-1:0]  r_ease_start_ms, n_ease_start_ms;
    logic [LEVEL_W-1:0] r_ease_start_level, n_ease_start_level;
    logic [KW-1:0]      r_ease_k, n_ease_k;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic signed [3:0]  r_focused, n_focused;

    logic               act;
    logic               cand_ok;
    logic               start;
    logic [TIME_W-1:0]  elapsed;
    logic               ease_done;
    logic [PW-1:0]      product;
    logic [LEVEL_W-1:0] step_q;
    logic [LEVEL_W-1:0] start_delta;
    logic [KW-1:0]      new_k;
    logic [LEVEL_W-1:0] start_goal;

    assign act         = i_word.pose_valid & i_word.follow_request;
    assign cand_ok     = !i_word.candidate_slot[3] &&
                         (int'({1'b0, i_word.candidate_slot[2:0]}) < SLOT_COUNT);
    assign elapsed     = i_word.time_ms - r_ease_start_ms;
    assign ease_done   = elapsed >= EASE_LEN;
    assign product     = PW'(r_ease_k) * PW'(elapsed[EW-1:0]);
    assign step_q      = product[SH +: LEVEL_W];
    assign start_delta = act ? (FULL_LEVEL - r_level) : r_level;
    assign new_k       = KW'(start_delta) * KW'(RECIP);
    assign start_goal  = act ? FULL_LEVEL : ZERO_LEVEL;

    always_comb begin
        n_prev_active      = act;
        n_window_open      = r_window_open;
        n_window_end       = r_window_end;
        n_ease_running     = r_ease_running;
        n_ease_goal_full   = r_ease_goal_full;
        n_ease_start_ms    = r_ease_start_ms;
        n_ease_start_level = r_ease_start_level;
        n_ease_k           = r_ease_k;
        n_level            = r_level;
        n_focused          = r_focused;
        start              = 1'b0;

        if (act != r_prev_active) begin
            if (act) begin
                n_window_open = 1'b0;
                if (cand_ok) begin
                    n_focused = i_word.candidate_slot;
                    start     = 1'b1;
                end
            end else begin
                n_window_open = 1'b1;
                n_window_end  = i_word.time_ms + TIME_W'(r_cfg_window);
                start         = !r_focused[3];
            end
        end

        if (start) begin
            // elapsed is zero on the start word, so level stays put
            n_ease_start_level = r_level;
            n_ease_goal_full   = act;
            n_ease_start_ms    = i_word.time_ms;
            n_ease_k           = new_k;
            n_ease_running     = r_level != start_goal;
            if (!n_ease_running && !act) begin
                n_focused = NO_SLOT;
            end
        end else if (r_ease_running) begin
            if (ease_done) begin
                n_level        = r_ease_goal_full ? FULL_LEVEL : ZERO_LEVEL;
                n_ease_running = 1'b0;
                if (!r_ease_goal_full) begin
                    n_focused = NO_SLOT;
                end
            end else if (r_ease_goal_full) begin
                n_level = r_ease_start_level + step_q;
            end else begin
                n_level = r_ease_start_level - step_q;
            end
        end

        if (n_window_open && (i_word.time_ms >= n_window_end)) begin
            n_window_open = 1'b0;
        end

        o_result.use_origin     = act | n_window_open;
        o_result.pose_held      = i_word.pose_valid;
        o_result.reported_slot  = act ? n_focused : NO_SLOT;
        o_result.progress_level = n_level;
        o_result.query_centring = i_word.pose_valid &&
                                  (i_word.query_slot == n_focused) &&
                                  (n_level != ZERO_LEVEL);
        o_result.easing         = n_ease_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_window <= WINDOW_RESET;
        end else if (i_cfg_valid) begin
            r_cfg_window <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_active      <= 1'b0;
            r_window_open      <= 1'b0;
            r_window_end       <= '0;
            r_ease_running     <= 1'b0;
            r_ease_goal_full   <= 1'b0;
            r_ease_start_ms    <= '0;
            r_ease_start_level <= ZERO_LEVEL;
            r_ease_k           <= '0;
            r_level            <= ZERO_LEVEL;
            r_focused          <= NO_SLOT;
        end else if (i_step) begin
            r_prev_active      <= n_prev_active;
            r_window_open      <= n_window_open;
            r_window_end       <= n_window_end;
            r_ease_running     <= n_ease_running;
            r_ease_goal_full   <= n_ease_goal_full;
            r_ease_start_ms    <= n_ease_start_ms;
            r_ease_start_level <= n_ease_start_level;
            r_ease_k           <= n_ease_k;
            r_level            <= n_level;
            r_focused          <= n_focused;
        end
    end

endmodule

FILE: sv/fmtc_out_reg.sv
// Result register: holds one result word for the master stream.
`timescale 1ns / 1ps
module fmtc_out_reg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  fmtc_pkg::t_out_word            i_word,
    input  logic                           i_ready,
    output logic                           o_free,
    output logic                           o_valid,
    output logic [fmtc_pkg::M_TDATA_W-1:0] o_data
);
    import fmtc_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = {{(M_TDATA_W - OUT_W){1'b0}}, r_word};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_word <= i_word;
        end
    end

endmodule

FILE: sv/follow_mode_transition_controller_top.sv
// Top level: follow-mode transition controller with stream ports and config write.
// Path: a slave word is held in the input register, then its result in the result
// register; the core steps only when the result register is free or being taken.
// Throughput: one word per cycle unless the master stalls; one core state update per word.
// The level ease uses two multiplies per word (delta by reciprocal, then by elapsed), no divider.
// Reset: synchronous, active low; clears all state, focus to none, window length to 750 ms.
`timescale 1ns / 1ps
module follow_mode_transition_controller_top #(
    parameter int EASE_MS = fmtc_pkg::EASE_MS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // fields from bit 0: pose_valid, follow_request, time_ms[63:0],
    // candidate_slot[3:0], query_slot[3:0], zero fill
    input  logic [fmtc_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // fields from bit 0: use_origin, pose_held, reported_slot[3:0],
    // progress_level[16:0], query_centring, easing, zero fill
    output logic [fmtc_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // disabling_window_ms
    input  logic [fmtc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready
);
    import fmtc_pkg::*;

    t_in_word  in_word;
    t_out_word result;
    logic      in_valid;
    logic      out_free;
    logic      step;

    assign step        = in_valid && out_free;
    assign o_cfg_ready = 1'b1;

    fmtc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .i_take  (step),
        .o_valid (in_valid),
        .o_word  (in_word)
    );

    fmtc_core #(
        .EASE_MS (EASE_MS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .i_word      (in_word),
        .o_result    (result)
    );

    fmtc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_word  (result),
        .i_ready (i_m_tready),
        .o_free  (out_free),
        .o_valid (o_m_tvalid),
        .o_data  (o_m_tdata)
    );

endmodule

FILE: sv/fmtc_checker.sv
// Checker: port-level properties of the controller, bound to the top level.
`timescale 1ns / 1ps
module fmtc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic [fmtc_pkg::S_TDATA_W-1:0] i_s_tdata,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [fmtc_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [fmtc_pkg::CFG_W-1:0]     i_cfg_data,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready
);
    import fmtc_pkg::*;

    t_out_word m_word;
    assign m_word = t_out_word'(o_m_tdata[OUT_W-1:0]);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result word changed");

    a_slot_needs_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (m_word.reported_slot != NO_SLOT)
        |-> m_word.use_origin && m_word.pose_held)
        else $error("slot reported without follow mode");

    a_centring_needs_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && m_word.query_centring
        |-> m_word.pose_held && (m_word.progress_level != ZERO_LEVEL))
        else $error("centring reported without pose or level");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !m_word.progress_level[16] || (m_word.progress_level[15:0] == 16'd0))
        else $error("progress level above full");

endmodule

bind follow_mode_transition_controller_top fmtc_checker u_fmtc_checker (.*);

FILE: verif/tb.sv
// Testbench for the follow-mode transition controller: directed and random updates, scoreboard.
`timescale 1ns / 1ps
module tb;
    import fmtc_pkg::*;

    localparam int EASE        = EASE_MS_DEF;
    localparam int STALL_LIMIT = 2000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;

    follow_mode_transition_controller_top #(
        .EASE_MS (EASE)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_data  (i_cfg_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready)
    );

    t_in_word  update_q[$];
    t_out_word status_due[$];
    int        fails;
    int        cyc_cnt;
    int        stall_cnt;
    logic      calm;

    // shadow of the controller state
    logic                     fs_prev_act;
    logic                     fs_win_open;
    logic [TIME_W-1:0]        fs_win_end;
    logic [CFG_W-1:0]         fs_win_len;
    logic                     fs_ease_run;
    logic [LEVEL_W-1:0]       fs_from;
    logic                     fs_up;
    logic [TIME_W-1:0]        fs_t0;
    logic [LEVEL_W-1:0]       fs_level;
    logic signed [3:0]        fs_focus;

    // stimulus state
    logic [TIME_W-1:0]        clock_ms;
    bit                       want_follow;
    logic signed [3:0]        hot_slot;

    always #10 i_clk = ~i_clk;

    assign calm = (cyc_cnt % 1500) >= 1150;

    task automatic step_follow_state(input t_in_word w);
        t_out_word          r;
        logic               act;
        logic               kick;
        logic               kick_up;
        logic [LEVEL_W-1:0] goal;
        longint unsigned    elapsed;
        longint unsigned    span;
        act     = w.pose_valid & w.follow_request;
        kick    = 1'b0;
        kick_up = 1'b0;
        if (act != fs_prev_act) begin
            if (act) begin
                fs_win_open = 1'b0;
                if (w.candidate_slot >= 0 && w.candidate_slot < SLOT_COUNT) begin
                    fs_focus = w.candidate_slot;
                    kick     = 1'b1;
                    kick_up  = 1'b1;
                end
            end else begin
                fs_win_open = 1'b1;
                fs_win_end  = w.time_ms + 64'(fs_win_len);
                if (fs_focus >= 0)
                    kick = 1'b1;
            end
            fs_prev_act = act;
        end
        if (kick) begin
            goal        = kick_up ? FULL_LEVEL : ZERO_LEVEL;
            fs_from     = fs_level;
            fs_up       = kick_up;
            fs_t0       = w.time_ms;
            fs_ease_run = (fs_level != goal);
            if (!fs_ease_run) begin
                fs_level = goal;
                if (!kick_up)
                    fs_focus = NO_SLOT;
            end
        end
        if (fs_win_open && w.time_ms >= fs_win_end)
            fs_win_open = 1'b0;
        if (fs_ease_run) begin
            elapsed = w.time_ms - fs_t0;
            if (elapsed >= 64'(EASE)) begin
                fs_level    = fs_up ? FULL_LEVEL : ZERO_LEVEL;
                fs_ease_run = 1'b0;
                if (!fs_up)
                    fs_focus = NO_SLOT;
            end else if (fs_up) begin
                span     = 64'(FULL_LEVEL - fs_from);
                fs_level = LEVEL_W'(64'(fs_from) + span * elapsed / 64'(EASE));
            end else begin
                span     = 64'(fs_from);
                fs_level = LEVEL_W'(64'(fs_from) - span * elapsed / 64'(EASE));
            end
        end
        r.use_origin     = act | fs_win_open;
        r.pose_held      = w.pose_valid;
        r.reported_slot  = act ? fs_focus : NO_SLOT;
        r.progress_level = fs_level;
        r.query_centring = w.pose_valid && (w.query_slot == fs_focus) && (fs_level != ZERO_LEVEL);
        r.easing         = fs_ease_run;
        status_due.push_back(r);
    endtask

    task automatic push_update(input bit pose, input bit req, input logic [TIME_W-1:0] t,
                               input logic signed [3:0] cand, input logic signed [3:0] qry);
        t_in_word w;
        w.pose_valid     = pose;
        w.follow_request = req;
        w.time_ms        = t;
        w.candidate_slot = cand;
        w.query_slot     = qry;
        update_q.push_back(w);
    endtask

    task automatic queue_random(input int count);
        int                k;
        int                pick;
        int                r;
        bit                pose;
        bit                req;
        logic [TIME_W-1:0] dt;
        logic signed [3:0] cand;
        logic signed [3:0] qry;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            cand = ($urandom_range(99) < 85) ? 4'($urandom_range(7)) : 4'($urandom_range(15, 8));
            if (pick < 3) begin
                clock_ms = {$urandom, $urandom};
                pose     = 1'($urandom_range(1));
                req      = 1'($urandom_range(1));
            end else if (pick < 7) begin
                clock_ms = clock_ms - 64'($urandom_range(300, 1));
                pose     = 1'($urandom_range(1));
                req      = 1'($urandom_range(1));
            end else begin
                if ($urandom_range(99) < 12) begin
                    want_follow = !want_follow;
                    if (want_follow)
                        hot_slot = cand;
                end
                pose = ($urandom_range(99) < 90);
                req  = want_follow;
                r    = $urandom_range(99);
                if (r < 10)
                    dt = '0;
                else if (r < 80)
                    dt = 64'($urandom_range(40, 1));
                else if (r < 95)
                    dt = 64'($urandom_range(400, 41));
                else if (r < 99)
                    dt = 64'($urandom_range(2000, 401));
                else
                    dt = 64'($urandom_range(70000, 2001));
                clock_ms = clock_ms + dt;
            end
            r = $urandom_range(99);
            if (r < 50)
                qry = hot_slot;
            else if (r < 65)
                qry = NO_SLOT;
            else
                qry = 4'($urandom_range(15));
            push_update(pose, req, clock_ms, cand, qry);
        end
    endtask

    task automatic drain_updates();
        while (update_q.size() != 0 || i_s_tvalid || status_due.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_in_word             nxt;
        logic [S_TDATA_W-1:0] vec;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                step_follow_state(t_in_word'(i_s_tdata[IN_W-1:0]));
            if (!i_s_tvalid || o_s_tready) begin
                if (update_q.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
                    nxt            = update_q.pop_front();
                    vec            = '0;
                    vec[IN_W-1:0]  = nxt;
                    i_s_tdata     <= vec;
                    i_s_tvalid    <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_word got;
        t_out_word want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = t_out_word'(o_m_tdata[OUT_W-1:0]);
                if (status_due.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, got);
                    fails++;
                end else begin
                    want = status_due.pop_front();
                    compare_field("use_origin", want.use_origin, got.use_origin);
                    compare_field("pose_held", want.pose_held, got.pose_held);
                    compare_field("reported_slot", want.reported_slot, got.reported_slot);
                    compare_field("progress_level", want.progress_level, got.progress_level);
                    compare_field("query_centring", want.query_centring, got.query_centring);
                    compare_field("easing", want.easing, got.easing);
                end
            end
            i_m_tready <= calm || ($urandom_range(99) >= 24);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] windows[4];
        int               p;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tdata   = '0;
        i_s_tvalid  = 1'b0;
        i_m_tready  = 1'b0;
        i_cfg_data  = '0;
        i_cfg_valid = 1'b0;
        fails       = 0;
        cyc_cnt     = 0;
        stall_cnt   = 0;
        fs_prev_act = 1'b0;
        fs_win_open = 1'b0;
        fs_win_end  = '0;
        fs_win_len  = WINDOW_RESET;
        fs_ease_run = 1'b0;
        fs_from     = ZERO_LEVEL;
        fs_up       = 1'b0;
        fs_t0       = '0;
        fs_level    = ZERO_LEVEL;
        fs_focus    = NO_SLOT;
        want_follow = 1'b0;
        hot_slot    = NO_SLOT;
        windows[0]  = 16'd0;
        windows[1]  = 16'hFFFF;
        windows[2]  = 16'd1;
        windows[3]  = 16'($urandom_range(65534, 2));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle, pose only, follow on with no display, window open and expiry
        push_update(0, 0, 64'd0, -4'sd8, -4'sd8);
        push_update(1, 0, 64'd10, 4'sd7, NO_SLOT);
        push_update(1, 1, 64'd20, NO_SLOT, 4'sd0);
        push_update(1, 1, 64'd30, 4'sd3, 4'sd3);
        push_update(0, 1, 64'd40, 4'sd3, 4'sd3);
        push_update(0, 1, 64'd789, 4'sd3, NO_SLOT);
        push_update(0, 1, 64'd790, 4'sd3, NO_SLOT);
        // ease up with truncation, then full
        push_update(1, 1, 64'd1000, 4'sd7, 4'sd7);
        push_update(1, 1, 64'd1001, 4'sd7, 4'sd7);
        push_update(1, 1, 64'd1149, 4'sd7, 4'sd7);
        push_update(1, 1, 64'd1150, 4'sd7, 4'sd7);
        // ease back, interrupted by a new focus, then back to zero
        push_update(1, 0, 64'd1200, 4'sd0, 4'sd7);
        push_update(1, 0, 64'd1275, 4'sd0, 4'sd7);
        push_update(1, 1, 64'd1276, 4'sd2, 4'sd2);
        push_update(1, 1, 64'd1300, 4'sd2, 4'sd2);
        push_update(0, 1, 64'd1301, -4'sd8, 4'sd2);
        push_update(0, 1, 64'd1500, -4'sd8, NO_SLOT);
        // on and off at the same instant: ease back starts at zero
        push_update(1, 1, 64'd1501, 4'sd5, 4'sd5);
        push_update(1, 0, 64'd1501, 4'sd5, 4'sd5);
        push_update(1, 1, 64'd2000, 4'sd1, 4'sd1);
        push_update(1, 1, 64'd2200, 4'sd1, 4'sd1);
        push_update(1, 1, 64'd2300, 4'sd4, 4'sd1);
        // window end wraps past 2^64, time wraps
        push_update(0, 0, 64'hFFFF_FFFF_FFFF_FF00, 4'sd6, 4'sd1);
        push_update(1, 1, 64'hFFFF_FFFF_FFFF_FFFF, 4'sd6, 4'sd6);
        push_update(1, 0, 64'h0000_0000_0000_0010, 4'sd6, 4'sd6);
        clock_ms = 64'h10;
        queue_random(225);
        drain_updates();

        for (p = 0; p < 4; p++) begin
            i_cfg_data  <= windows[p];
            i_cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!o_cfg_ready);
            i_cfg_valid <= 1'b0;
            fs_win_len   = windows[p];
            queue_random(250);
            drain_updates();
        end

        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
